@@ hw/rtl/adti_pkg.sv @@
// Shared types, character codes and parser phase codes for the ASCII decimal parser.
package adti_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RES_WIDTH       = 32;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_POINT  = 2'd2;
  localparam logic [1:0] PH_BAD    = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } char_t;

  typedef struct packed {
    logic signed [RES_WIDTH-1:0] value;
    logic                        valid_res;
  } res_t;

endpackage

@@ hw/rtl/adti_if.sv @@
// Request channel interfaces for characters in and parsed integers out.
interface adti_in_if import adti_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_line;

  modport source (output valid, output char_code, output end_of_line, input ready);
  modport sink (input valid, input char_code, input end_of_line, output ready);
endinterface

interface adti_out_if import adti_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [RES_WIDTH-1:0] value;
  logic                        valid_res;

  modport source (output valid, output value, output valid_res, input ready);
  modport sink (input valid, input value, input valid_res, output ready);
endinterface

@@ hw/rtl/ascii_decimal_to_integer_core.sv @@
// A character flagged end_of_line reaches the output via the input and result registers.
// Throughput: one character per cycle unless stalled as below; the multiply-by-ten and
// add for each character (accumulator feedback loop) is combinational.
// A stalled result register holds an end_of_line character in the input register,
// which then blocks further requests until the result is taken.
// Reset (rst_n low, synchronous) empties both registers and clears phase, sign and value.
module ascii_decimal_to_integer_core import adti_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  adti_in_if.sink    in_ch,
  adti_out_if.source out_ch
);

  char_t in_item;
  char_t s1_item;
  logic  s1_vld;
  logic  s1_adv;
  logic  out_free;
  logic  load;
  res_t  res;
  res_t  res_q;

  assign in_item.char_code   = in_ch.char_code;
  assign in_item.end_of_line = in_ch.end_of_line;

  assign s1_adv = s1_vld && (!s1_item.end_of_line || out_free);
  assign load   = s1_adv && s1_item.end_of_line;

  adti_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .in_ready (in_ch.ready),
    .adv      (s1_adv),
    .s1_vld   (s1_vld),
    .s1_item  (s1_item)
  );

  adti_parse #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .item    (s1_item),
    .res     (res)
  );

  adti_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res_in    (res),
    .out_ready (out_ch.ready),
    .out_free  (out_free),
    .out_valid (out_ch.valid),
    .res_out   (res_q)
  );

  assign out_ch.value     = res_q.value;
  assign out_ch.valid_res = res_q.valid_res;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld && !s1_adv |=> s1_vld && $stable(s1_item))
    else $error("held character request lost or changed");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(s1_adv && s1_item.end_of_line))
    else $error("result appeared without an end-of-line character");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    load && !res.valid_res |=> out_ch.valid && out_ch.value == '0)
    else $error("invalid line produced nonzero value");

endmodule

@@ hw/rtl/adti_in_reg.sv @@
// Input register stage holding one character request.
module adti_in_reg import adti_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  char_t in_item,
  output logic  in_ready,
  input  logic  adv,
  output logic  s1_vld,
  output char_t s1_item
);

  logic  vld_r;
  logic  vld_nxt;
  char_t item_r;

  assign in_ready = !vld_r || adv;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_vld  = vld_r;
  assign s1_item = item_r;

endmodule

@@ hw/rtl/adti_parse.sv @@
// Parser state (phase, sign, accumulator) and per-character next-state and result logic.
module adti_parse import adti_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_en,
  input  char_t item,
  output res_t  res
);

  logic [1:0]             phase_r, phase_nxt;
  logic                   neg_r, neg_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [VALUE_WIDTH-1:0] acc_x10;
  logic [VALUE_WIDTH-1:0] mag;
  logic signed [VALUE_WIDTH-1:0] mag_s;
  logic                   is_digit;

  assign is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
  assign acc_x10  = (acc_r << 3) + (acc_r << 1)
                  + {{(VALUE_WIDTH-4){1'b0}}, item.char_code[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    unique case (phase_r) inside
      PH_START, PH_DIGITS: begin
        if (is_digit) begin
          acc_nxt   = acc_x10;
          phase_nxt = PH_DIGITS;
        end else if (item.char_code == CHAR_POINT) begin
          phase_nxt = PH_POINT;
        end else if (item.char_code == CHAR_MINUS && phase_r == PH_START) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_BAD;
        end
      end
      PH_POINT: begin
        if (item.char_code != CHAR_ZERO) begin
          phase_nxt = PH_BAD;
        end
      end
      default: phase_nxt = PH_BAD;
    endcase
  end

  assign mag   = neg_nxt ? (~acc_nxt + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : acc_nxt;
  assign mag_s = signed'(mag);

  always_comb begin
    if (phase_nxt == PH_BAD) begin
      res.value     = '0;
      res.valid_res = 1'b0;
    end else begin
      res.value     = RES_WIDTH'(mag_s);
      res.valid_res = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      neg_r   <= 1'b0;
      acc_r   <= '0;
    end else if (step_en) begin
      if (item.end_of_line) begin
        phase_r <= PH_START;
        neg_r   <= 1'b0;
        acc_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        acc_r   <= acc_nxt;
      end
    end
  end

endmodule

@@ hw/rtl/adti_out_reg.sv @@
// Result register holding one parsed integer until the sink takes it.
module adti_out_reg import adti_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_in,
  input  logic out_ready,
  output logic out_free,
  output logic out_valid,
  output res_t res_out
);

  logic vld_r;
  logic vld_nxt;
  res_t res_r;

  assign out_free = !vld_r || out_ready;
  assign vld_nxt  = load || (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = vld_r;
  assign res_out   = res_r;

endmodule
